/* design/svt_pkg.sv */
// sparse domain violation table: shared package
// op and status codes, item and result types used by the engine and the top level
// no dependencies
`timescale 1ns / 1ps

package svt_pkg;

   localparam int VAL_W  = 32;
   localparam int DIST_W = 16;

   // operation codes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_VALUE = 2'd1;
   localparam logic [1:0] OP_RANGE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_REJECT    = 2'd1;
   localparam logic [1:0] ST_NO_DOMAIN = 2'd2;

   typedef struct packed {
      logic [1:0]              op;
      logic signed [VAL_W-1:0] low_value;
      logic signed [VAL_W-1:0] high_value;
      logic                    restart;
   } svt_item_type;

   typedef struct packed {
      logic [VAL_W-1:0] min_violation;
      logic [VAL_W-1:0] max_violation;
      logic [1:0]       status;
   } svt_result_type;

endpackage

/* design/svt_store.sv */
// sparse domain violation table: distance store
// one write port and one read port, read data registered
// depends on svt_pkg for the entry width
`timescale 1ns / 1ps

module svt_store #(
   parameter int SPAN_DEPTH = 1024,
   parameter int ADDR_W     = 10
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [svt_pkg::DIST_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [svt_pkg::DIST_W-1:0] rd_data
);
   import svt_pkg::*;

   logic [DIST_W-1:0] mem [SPAN_DEPTH];
   logic [DIST_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/svt_engine.sv */
// sparse domain violation table: sequencer
// holds the domain bounds, fills the store on loads and scans it on queries that reach into the span
// depends on svt_pkg; drives the ports of svt_store
`timescale 1ns / 1ps

module svt_engine #(
   parameter int SPAN_DEPTH = 1024,
   parameter int ADDR_W     = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  svt_pkg::svt_item_type       item,
   output logic                        ready,
   output logic                        res_valid,
   output svt_pkg::svt_result_type     result,
   input  logic                        res_ready,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [svt_pkg::DIST_W-1:0]  wr_data,
   output logic                        rd_en,
   output logic [ADDR_W-1:0]           rd_addr,
   input  logic [svt_pkg::DIST_W-1:0]  rd_data
);
   import svt_pkg::*;

   localparam int XW = VAL_W + 1;
   localparam logic signed [XW-1:0] DEPTH_C = XW'(SPAN_DEPTH);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SWAP   = 4'd1;
   localparam logic [3:0] S_CALC   = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_FILL   = 4'd4;
   localparam logic [3:0] S_SCAN   = 4'd5;
   localparam logic [3:0] S_DRAIN  = 4'd6;
   localparam logic [3:0] S_MERGE  = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;

   logic [3:0] state_ff, state_in;

   // captured word
   logic [1:0]           op_ff, op_in;
   logic                 restart_ff, restart_in;
   logic signed [XW-1:0] lo_ff, lo_in, hi_ff, hi_in;

   // domain
   logic                    loaded_ff, loaded_in;
   logic signed [VAL_W-1:0] start_ff, start_in, end_ff, end_in;
   logic [ADDR_W-1:0]       end_off_ff, end_off_in;

   // differences against the domain bounds
   logic signed [XW-1:0] d_lo_start_ff, d_lo_start_in;
   logic signed [XW-1:0] d_hi_start_ff, d_hi_start_in;
   logic signed [XW-1:0] d_hi_lo_ff, d_hi_lo_in;
   logic signed [XW-1:0] d_lo_end_ff, d_lo_end_in;
   logic signed [XW-1:0] d_hi_end_ff, d_hi_end_in;

   // walk over the store
   logic [ADDR_W-1:0] ptr_ff, ptr_in, last_ff, last_in;
   logic [ADDR_W-1:0] gap_ff, gap_in, base_ff, base_in;
   logic              rd_pend_ff;

   // result accumulation
   logic [VAL_W-1:0] least_ff, least_in, most_ff, most_in;
   logic [VAL_W-1:0] ext_lo_ff, ext_lo_in, ext_hi_ff, ext_hi_in;
   logic [VAL_W-1:0] ext_max_ff, ext_max_in;
   logic [1:0]       status_ff, status_in;

   logic signed [XW-1:0] neg_lo_start, neg_hi_start;
   logic [ADDR_W-1:0]    gap_a, gap_b;
   logic [VAL_W-1:0]     rd_ext;
   logic                 new_dom;

   assign neg_lo_start = -d_lo_start_ff;
   assign neg_hi_start = -d_hi_start_ff;
   assign new_dom      = restart_ff || !loaded_ff;
   assign rd_ext       = VAL_W'(rd_data);

   // gap entry: distance to the nearer of the two neighbouring intervals
   assign gap_a = ptr_ff - base_ff;
   assign gap_b = gap_ff - ptr_ff;

   // store ports
   assign wr_en   = (state_ff == S_FILL);
   assign wr_addr = ptr_ff;
   assign wr_data = (ptr_ff < gap_ff) ? DIST_W'((gap_a < gap_b) ? gap_a : gap_b) : '0;
   assign rd_en   = (state_ff == S_SCAN);
   assign rd_addr = ptr_ff;

   assign ready     = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_FINISH);
   assign result    = '{min_violation: least_ff, max_violation: most_ff, status: status_ff};

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      restart_in    = restart_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      loaded_in     = loaded_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      end_off_in    = end_off_ff;
      d_lo_start_in = d_lo_start_ff;
      d_hi_start_in = d_hi_start_ff;
      d_hi_lo_in    = d_hi_lo_ff;
      d_lo_end_in   = d_lo_end_ff;
      d_hi_end_in   = d_hi_end_ff;
      ptr_in        = ptr_ff;
      last_in       = last_ff;
      gap_in        = gap_ff;
      base_in       = base_ff;
      least_in      = least_ff;
      most_in       = most_ff;
      ext_lo_in     = ext_lo_ff;
      ext_hi_in     = ext_hi_ff;
      ext_max_in    = (ext_lo_ff > ext_hi_ff) ? ext_lo_ff : ext_hi_ff;
      status_in     = status_ff;

      // fold in store data in the cycle after each read
      if (rd_pend_ff) begin
         if (rd_ext < least_ff) least_in = rd_ext;
         if (rd_ext > most_ff)  most_in  = rd_ext;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = item.op;
               restart_in = item.restart;
               lo_in      = XW'(item.low_value);
               hi_in      = XW'(item.high_value);
               state_in   = S_SWAP;
            end
         end
         S_SWAP: begin
            // reversed range
            if (op_ff == OP_RANGE && lo_ff > hi_ff) begin
               lo_in = hi_ff;
               hi_in = lo_ff;
            end
            state_in = S_CALC;
         end
         S_CALC: begin
            d_lo_start_in = lo_ff - XW'(start_ff);
            d_hi_start_in = hi_ff - XW'(start_ff);
            d_hi_lo_in    = hi_ff - lo_ff;
            d_lo_end_in   = lo_ff - XW'(end_ff);
            d_hi_end_in   = hi_ff - XW'(end_ff);
            state_in      = S_DECIDE;
         end
         S_DECIDE: begin
            least_in  = '0;
            most_in   = '0;
            ext_lo_in = '0;
            ext_hi_in = '0;
            status_in = ST_OK;
            state_in  = S_FINISH;
            case (op_ff)
               OP_LOAD: begin
                  if (d_hi_lo_ff < 0) begin
                     status_in = ST_REJECT;
                  end else if (new_dom) begin
                     if (d_hi_lo_ff >= DEPTH_C) begin
                        status_in = ST_REJECT;
                     end else begin
                        loaded_in  = 1'b1;
                        start_in   = lo_ff[VAL_W-1:0];
                        end_in     = hi_ff[VAL_W-1:0];
                        end_off_in = d_hi_lo_ff[ADDR_W-1:0];
                        ptr_in     = '0;
                        last_in    = d_hi_lo_ff[ADDR_W-1:0];
                        gap_in     = '0;
                        base_in    = '0;
                        state_in   = S_FILL;
                     end
                  end else if (d_lo_end_ff <= 0 || d_hi_start_ff >= DEPTH_C) begin
                     // out of order or span too wide
                     status_in = ST_REJECT;
                  end else begin
                     end_in     = hi_ff[VAL_W-1:0];
                     end_off_in = d_hi_start_ff[ADDR_W-1:0];
                     ptr_in     = end_off_ff + ADDR_W'(1);
                     last_in    = d_hi_start_ff[ADDR_W-1:0];
                     gap_in     = d_lo_start_ff[ADDR_W-1:0];
                     base_in    = end_off_ff;
                     state_in   = S_FILL;
                  end
               end
               OP_VALUE: begin
                  if (!loaded_ff) begin
                     status_in = ST_NO_DOMAIN;
                  end else if (d_lo_start_ff < 0) begin
                     least_in = neg_lo_start[VAL_W-1:0];
                     most_in  = neg_lo_start[VAL_W-1:0];
                  end else if (d_lo_end_ff > 0) begin
                     least_in = d_lo_end_ff[VAL_W-1:0];
                     most_in  = d_lo_end_ff[VAL_W-1:0];
                  end else begin
                     least_in = '1;
                     ptr_in   = d_lo_start_ff[ADDR_W-1:0];
                     last_in  = d_lo_start_ff[ADDR_W-1:0];
                     state_in = S_SCAN;
                  end
               end
               OP_RANGE: begin
                  if (!loaded_ff) begin
                     status_in = ST_NO_DOMAIN;
                  end else if (d_hi_start_ff < 0) begin
                     // range wholly below the span
                     least_in = neg_hi_start[VAL_W-1:0];
                     most_in  = neg_lo_start[VAL_W-1:0];
                  end else if (d_lo_end_ff > 0) begin
                     // range wholly above the span
                     least_in = d_lo_end_ff[VAL_W-1:0];
                     most_in  = d_hi_end_ff[VAL_W-1:0];
                  end else begin
                     least_in = '1;
                     if (d_lo_start_ff < 0) begin
                        ptr_in    = '0;
                        ext_lo_in = neg_lo_start[VAL_W-1:0];
                     end else begin
                        ptr_in = d_lo_start_ff[ADDR_W-1:0];
                     end
                     if (d_hi_end_ff > 0) begin
                        last_in   = end_off_ff;
                        ext_hi_in = d_hi_end_ff[VAL_W-1:0];
                     end else begin
                        last_in = d_hi_start_ff[ADDR_W-1:0];
                     end
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end
         S_FILL: begin
            ptr_in = ptr_ff + ADDR_W'(1);
            if (ptr_ff == last_ff) state_in = S_FINISH;
         end
         S_SCAN: begin
            ptr_in = ptr_ff + ADDR_W'(1);
            if (ptr_ff == last_ff) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_MERGE;
         end
         S_MERGE: begin
            // parts of the range beyond the span
            if (ext_max_ff > most_ff) most_in = ext_max_ff;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         loaded_ff  <= 1'b0;
         start_ff   <= '0;
         end_ff     <= '0;
         end_off_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         loaded_ff  <= loaded_in;
         start_ff   <= start_in;
         end_ff     <= end_in;
         end_off_ff <= end_off_in;
         rd_pend_ff <= (state_ff == S_SCAN);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      restart_ff    <= restart_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      d_lo_start_ff <= d_lo_start_in;
      d_hi_start_ff <= d_hi_start_in;
      d_hi_lo_ff    <= d_hi_lo_in;
      d_lo_end_ff   <= d_lo_end_in;
      d_hi_end_ff   <= d_hi_end_in;
      ptr_ff        <= ptr_in;
      last_ff       <= last_in;
      gap_ff        <= gap_in;
      base_ff       <= base_in;
      least_ff      <= least_in;
      most_ff       <= most_in;
      ext_lo_ff     <= ext_lo_in;
      ext_hi_ff     <= ext_hi_in;
      ext_max_ff    <= ext_max_in;
      status_ff     <= status_in;
   end

endmodule

/* design/sparse_domain_violation_table_top.sv */
// Sequence: each word passes the swap, calc and decide states; an accepted load then fills
// its store entries, and a query that reaches into the span scans, drains and merges.
// Throughput: one word at a time, the next accepted only once the output register has taken
// the result; the store has a single write port (fill) and a single read port (scan).
// Reset: synchronous, clears the sequencer, the domain and the output valid flag; the
// store is not cleared, since every entry a query reads was written by an earlier load.
`timescale 1ns / 1ps

// top level: stream ports, output register, sequencer and distance store
// depends on svt_pkg, svt_engine and svt_store
module sparse_domain_violation_table_top #(
   parameter int SPAN_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // low_value[31:0], high_value[63:32], restart[64], zero pad
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // min_violation[31:0], max_violation[63:32],
                                    // status[65:64], zero pad
);
   import svt_pkg::*;

   localparam int ADDR_W = (SPAN_DEPTH > 1) ? $clog2(SPAN_DEPTH) : 1;

   svt_item_type      item;
   svt_result_type    eng_result;
   logic              eng_ready, eng_valid, eng_take;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DIST_W-1:0] wr_data, rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   svt_result_type    rsp_data_ff, rsp_data_in;

   // unpack the request word
   assign item = '{op:         req_tuser,
                   low_value:  req_tdata[31:0],
                   high_value: req_tdata[63:32],
                   restart:    req_tdata[64]};

   assign req_tready = eng_ready;
   assign eng_take   = !rsp_valid_ff || rsp_tready;

   svt_engine #(.SPAN_DEPTH(SPAN_DEPTH), .ADDR_W(ADDR_W)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && req_tready),
      .item      (item),
      .ready     (eng_ready),
      .res_valid (eng_valid),
      .result    (eng_result),
      .res_ready (eng_take),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   svt_store #(.SPAN_DEPTH(SPAN_DEPTH), .ADDR_W(ADDR_W)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (eng_valid && eng_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.status, rsp_data_ff.max_violation,
                        rsp_data_ff.min_violation};

`ifndef NO_ASSERTIONS
   // one word in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a word is in progress");

   // store is never written and read in the same cycle
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("fill and scan overlap");

   // status code is always a defined one
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[65:64] == ST_OK || rsp_tdata[65:64] == ST_REJECT ||
                      rsp_tdata[65:64] == ST_NO_DOMAIN))
      else $error("undefined status code");

   // an error carries no distances
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65:64] != ST_OK |-> rsp_tdata[63:0] == 64'd0)
      else $error("distances on an error response");

   // least distance never exceeds greatest
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:0] <= rsp_tdata[63:32])
      else $error("min_violation above max_violation");
`endif

endmodule
